/* rtl/smst_pkg.sv */
// Shared constants, widths and the front-end request type for the fixed-point
// smootherstep block. No dependencies; every rtl file refers to it by scoped name.
package smst_pkg;

  // Fixed-point format and port widths
  localparam int FRAC_BITS       = 10;
  localparam int SAMPLE_WIDTH    = 20;
  localparam int LEVEL_WIDTH     = 11;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = SAMPLE_WIDTH;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EDGE_LOW  = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EDGE_HIGH = 1'b1;

  // Register reset values
  localparam logic [SAMPLE_WIDTH-1:0] EDGE_LOW_RESET  = '0;
  localparam logic [SAMPLE_WIDTH-1:0] EDGE_HIGH_RESET = SAMPLE_WIDTH'(1024);

  // Normalised t runs 0..2^FRAC_BITS
  localparam int SCALE   = 1 << FRAC_BITS;
  localparam int T_WIDTH = FRAC_BITS + 1;
  localparam logic [T_WIDTH-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Polynomial datapath widths
  localparam int A_WIDTH  = FRAC_BITS + 5;        // signed, holds -15*SCALE
  localparam int U_WIDTH  = FRAC_BITS + 4;        // unsigned, holds 10*SCALE
  localparam int P1_WIDTH = A_WIDTH + T_WIDTH + 1; // signed first product
  localparam int P_WIDTH  = U_WIDTH + T_WIDTH;     // unsigned later products

  localparam logic signed [A_WIDTH-1:0] FIFTEEN_S = A_WIDTH'(15 * SCALE);
  localparam logic signed [A_WIDTH-1:0] TEN_S     = A_WIDTH'(10 * SCALE);
  localparam int LEVEL_MAX = (1 << LEVEL_WIDTH) - 1;

  // Front end to divider: remainder and divisor, or a pinned result
  typedef struct packed {
    logic                    pinned;
    logic [T_WIDTH-1:0]      t_forced;
    logic [SAMPLE_WIDTH-1:0] rem;
    logic [SAMPLE_WIDTH-1:0] span;
  } smst_norm_t;

endpackage

/* rtl/smst_norm.sv */
// Front end of the smootherstep pipeline: offset, span and the pinned cases.
// Two register stages; depends on smst_pkg.
module smst_norm (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [smst_pkg::SAMPLE_WIDTH-1:0]    in_sample,
  input  logic [smst_pkg::SAMPLE_WIDTH-1:0]    edge_low,
  input  logic [smst_pkg::SAMPLE_WIDTH-1:0]    edge_high,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output smst_pkg::smst_norm_t                 out_data
);

  logic                              v_r [2];
  logic [2:0]                        en;
  logic                              le_a_r;
  logic                              rev_a_r;
  logic [smst_pkg::SAMPLE_WIDTH-1:0] d_a_r;
  logic [smst_pkg::SAMPLE_WIDTH-1:0] span_a_r;
  smst_pkg::smst_norm_t              data_b_nxt;
  smst_pkg::smst_norm_t              data_b_r;

  // Advance a stage when it is empty or the next one advances
  assign en[2]    = !out_stall;
  assign en[1]    = !v_r[1] || en[2];
  assign en[0]    = !v_r[0] || en[1];
  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
      v_r[1] <= 1'b0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  // Stage A: offset from the lower edge, span, edge order
  always_ff @(posedge clk) begin
    if (en[0]) begin
      le_a_r   <= (in_sample <= edge_low);
      rev_a_r  <= (edge_high <= edge_low);
      d_a_r    <= in_sample - edge_low;
      span_a_r <= edge_high - edge_low;
    end
  end

  // Stage B: pin to 0 at/below edge_low, else to one if edges reverse or d >= span
  always_comb begin
    data_b_nxt.pinned   = le_a_r || rev_a_r || (d_a_r >= span_a_r);
    data_b_nxt.t_forced = le_a_r ? '0 : smst_pkg::T_ONE;
    data_b_nxt.rem      = d_a_r;
    data_b_nxt.span     = span_a_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) data_b_r <= data_b_nxt;
  end

  assign out_valid = v_r[1];
  assign out_data  = data_b_r;

endmodule

/* rtl/smst_div.sv */
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS stages.
// Produces t in 0..2^FRAC_BITS; depends on smst_pkg.
module smst_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  smst_pkg::smst_norm_t            in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [smst_pkg::T_WIDTH-1:0]    out_t
);

  localparam int F = smst_pkg::FRAC_BITS;
  localparam int W = smst_pkg::SAMPLE_WIDTH;

  logic                 v_r  [F];
  logic [F:0]           en;
  smst_pkg::smst_norm_t st_r [F];
  logic [F-1:0]         q_r  [F];

  assign en[F]    = !out_stall;
  assign in_stall = !en[0];

  for (genvar k = 0; k < F; k++) begin : g_step
    smst_pkg::smst_norm_t src;
    smst_pkg::smst_norm_t st_nxt;
    logic [F-1:0]         q_src;
    logic                 v_src;
    logic [W:0]           dbl;
    logic                 ge;

    if (k == 0) begin : g_first
      assign src   = in_data;
      assign q_src = '0;
      assign v_src = in_valid;
    end else begin : g_next
      assign src   = st_r[k-1];
      assign q_src = q_r[k-1];
      assign v_src = v_r[k-1];
    end

    // Advance when empty or the next stage advances
    assign en[k] = !v_r[k] || en[k+1];

    // Shift the remainder and try the subtraction
    assign dbl = {src.rem, 1'b0};
    assign ge  = (dbl >= {1'b0, src.span});

    always_comb begin
      st_nxt     = src;
      st_nxt.rem = ge ? W'(dbl - {1'b0, src.span}) : dbl[W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= st_nxt;
        q_r[k]  <= {q_src[F-2:0], ge};
      end
    end
  end

  // Select the pinned value or the quotient
  assign out_valid = v_r[F-1];
  assign out_t     = st_r[F-1].pinned ? st_r[F-1].t_forced : {1'b0, q_r[F-1]};

  // Remainder stays below the divisor on the working path
  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[F-1] && !st_r[F-1].pinned |-> st_r[F-1].rem < st_r[F-1].span)
    else $error("divider remainder not below span");

endmodule

/* rtl/smst_poly.sv */
// Horner evaluation of t^3(6t^2-15t+10) in fixed point, seven register stages,
// multipliers in stages 1, 3, 4 and 5, each registered; depends on smst_pkg.
module smst_poly (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [smst_pkg::T_WIDTH-1:0]       in_t,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [smst_pkg::LEVEL_WIDTH-1:0]   out_level
);

  localparam int F   = smst_pkg::FRAC_BITS;
  localparam int TW  = smst_pkg::T_WIDTH;
  localparam int AW  = smst_pkg::A_WIDTH;
  localparam int UW  = smst_pkg::U_WIDTH;
  localparam int P1W = smst_pkg::P1_WIDTH;
  localparam int PW  = smst_pkg::P_WIDTH;
  localparam int NS  = 7;

  logic                            v_r [NS];
  logic [NS:0]                     en;
  logic [TW-1:0]                   t0_r, t1_r, t2_r, t3_r, t4_r;
  logic signed [AW-1:0]            tx;
  logic signed [AW-1:0]            a1_nxt;
  logic signed [AW-1:0]            a1_r;
  logic signed [P1W-1:0]           p1_r;
  logic signed [P1W-1:0]           bias;
  logic signed [P1W-1:0]           p1_sum;
  logic signed [P1W-1:0]           p1_shr;
  logic signed [AW-1:0]            a3_nxt;
  logic [UW-1:0]                   a3_r;
  logic [PW-1:0]                   p2_r, p3_r, p4_r;
  logic [PW-F-1:0]                 hi;
  logic [smst_pkg::LEVEL_WIDTH-1:0] lvl_nxt;
  logic [smst_pkg::LEVEL_WIDTH-1:0] lvl_r;

  // Stall chain and valid bits
  assign en[NS]   = !out_stall;
  assign in_stall = !en[0];

  for (genvar k = 0; k < NS; k++) begin : g_ctl
    assign en[k] = !v_r[k] || en[k+1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Stage 0: a = 6t - 15
  assign tx     = $signed(AW'(in_t));
  assign a1_nxt = (tx <<< 2) + (tx <<< 1) - smst_pkg::FIFTEEN_S;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0_r <= in_t;
      a1_r <= a1_nxt;
    end
  end

  // Stage 1: signed product a*t
  always_ff @(posedge clk) begin
    if (en[1]) begin
      t1_r <= t0_r;
      p1_r <= P1W'(a1_r) * P1W'($signed({1'b0, t0_r}));
    end
  end

  // Stage 2: scale down toward zero, add 10
  assign bias   = p1_r[P1W-1] ? P1W'(smst_pkg::SCALE - 1) : '0;
  assign p1_sum = p1_r + bias;
  assign p1_shr = p1_sum >>> F;
  assign a3_nxt = $signed(p1_shr[AW-1:0]) + smst_pkg::TEN_S;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t2_r <= t1_r;
      a3_r <= a3_nxt[UW-1:0];
    end
  end

  // Stages 3 to 5: three products by t, now all non-negative
  always_ff @(posedge clk) begin
    if (en[3]) begin
      t3_r <= t2_r;
      p2_r <= PW'(a3_r) * PW'(t2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      t4_r <= t3_r;
      p3_r <= PW'(p2_r[F+UW-1:F]) * PW'(t3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      p4_r <= PW'(p3_r[F+UW-1:F]) * PW'(t4_r);
    end
  end

  // Stage 6: scale down and saturate to the level width
  assign hi = p4_r[PW-1:F];
  always_comb begin
    if (32'(hi) > 32'(smst_pkg::LEVEL_MAX)) begin
      lvl_nxt = '1;
    end else begin
      lvl_nxt = smst_pkg::LEVEL_WIDTH'(hi);
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) lvl_r <= lvl_nxt;
  end

  assign out_valid = v_r[NS-1];
  assign out_level = lvl_r;

  // After adding 10 the accumulator is at least one
  a_bias_positive: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> a3_r >= UW'(smst_pkg::SCALE))
    else $error("accumulator below one after bias");

endmodule

/* rtl/fixed_point_smootherstep_top.sv */
// Top level of the fixed-point smootherstep block: edge registers and the
// front end, divider and polynomial pipelines. Depends on smst_pkg and submodules.
//
// Usage:
//   Input requests carry one unsigned Q10 sample on in_sample, handed over with
//   in_valid and in_stall; each request gives exactly one Q10 result on
//   out_level, handed over with out_valid and out_stall.
//   edge_low (index 0) and edge_high (index 1) are written through cfg_wr_en,
//   cfg_index and cfg_wdata; the user must write them only while no request is
//   in flight, as the block itself does not enforce this. Each request passes
//   through two front-end stages, one divider stage per quotient bit and seven
//   polynomial stages. Throughput is one request per cycle; the pipeline takes
//   a new request every cycle while it keeps moving.
//   When the receiver stalls, stages hold their requests and empty stages
//   behind them keep filling; in_stall rises only once every stage is full.
//   Synchronous reset empties the pipeline and sets edge_low to 0 and
//   edge_high to 1024.
module fixed_point_smootherstep_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [smst_pkg::SAMPLE_WIDTH-1:0]     in_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [smst_pkg::LEVEL_WIDTH-1:0]      out_level,
  input  logic                                  cfg_wr_en,
  input  logic [smst_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [smst_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);

  logic [smst_pkg::SAMPLE_WIDTH-1:0] edge_low_r;
  logic [smst_pkg::SAMPLE_WIDTH-1:0] edge_high_r;
  logic                              norm_valid;
  logic                              norm_stall;
  smst_pkg::smst_norm_t              norm_data;
  logic                              div_valid;
  logic                              div_stall;
  logic [smst_pkg::T_WIDTH-1:0]      div_t;

  // Hold the edge registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_low_r  <= smst_pkg::EDGE_LOW_RESET;
      edge_high_r <= smst_pkg::EDGE_HIGH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        smst_pkg::REG_EDGE_LOW:  edge_low_r  <= cfg_wdata;
        smst_pkg::REG_EDGE_HIGH: edge_high_r <= cfg_wdata;
      endcase
    end
  end

  smst_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .edge_low  (edge_low_r),
    .edge_high (edge_high_r),
    .out_valid (norm_valid),
    .out_stall (norm_stall),
    .out_data  (norm_data)
  );

  smst_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (norm_valid),
    .in_stall  (norm_stall),
    .in_data   (norm_data),
    .out_valid (div_valid),
    .out_stall (div_stall),
    .out_t     (div_t)
  );

  smst_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_stall  (div_stall),
    .in_t      (div_t),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_level (out_level)
  );

  // Input stalls only with a full pipeline blocked at the output
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // Reset empties the pipeline
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
